FILE: sv/sfba_pkg.sv
// package for the segregated fit block allocator
// holds sizes, size class table, codes and the controller/datapath command types
// no dependencies
package sfba_pkg;

	localparam int HEAP_GRANULES = 4096;
	localparam int SIZE_CLASSES  = 48;
	localparam int G_W           = $clog2(HEAP_GRANULES);
	localparam int L_W           = G_W + 1;
	localparam int CLS_W         = $clog2(SIZE_CLASSES);
	localparam int HDR_W         = 8;
	localparam int B_W           = 17;
	localparam int PADDR_W       = 3;
	localparam int HEAP_CLS      = 15;
	localparam int MIN_BLOCK     = 64;

	localparam logic [L_W-1:0]   LINK_NULL  = L_W'(HEAP_GRANULES);
	localparam logic [HDR_W-1:0] HDR_RESET  = 8'd96;
	localparam logic [CLS_W-1:0] CLS_LAST   = CLS_W'(SIZE_CLASSES - 1);
	localparam logic             REG_HDR    = 1'b0;

	typedef enum logic [1:0] {
		RS_DONE    = 2'd0,
		RS_ZERO    = 2'd1,
		RS_NOFIT   = 2'd2,
		RS_IGNORED = 2'd3
	} rs_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_CLR, OP_LATCH, OP_CLS_STEP, OP_CLS_INC, OP_HEAD_RD, OP_G_HEAD,
		OP_REC_RD, OP_G_NEXT, OP_A_TAKE, OP_RM_P, OP_RM_N, OP_RM_SELF, OP_SPLIT_SET,
		OP_P_NODE, OP_P_AFTER, OP_P_LINK, OP_P_HSET, OP_A_DONE, OP_F_TAKE, OP_L_RD,
		OP_L_TAKE, OP_CLR_OG, OP_R_RD, OP_R_TAKE, OP_F_PUSH, OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		rs_t    st;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic req_zero;
		logic too_big;
		logic addr_bad;
		logic head_null;
		logic c_last;
		logic cls_hit;
		logic fit;
		logic next_null;
		logic g_start;
		logic g_free;
		logic left_ok;
		logic r_in;
		logic split;
		logic out_free;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DEC, S_A_CLS, S_A_HRD, S_A_HCHK, S_A_GRD, S_A_GCHK,
		S_RM_P, S_RM_N, S_RM_SELF, S_A_SPLIT, S_P_CLS, S_P_HRD, S_P_NODE, S_P_AFTER,
		S_P_LINK, S_P_HSET, S_A_DONE, S_F_RD, S_F_CHK, S_F_LCHK, S_F_LGET, S_F_CLRG,
		S_F_RRD, S_F_RGET, S_F_PUSH, S_FIN
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PH_ALLOC, PH_LEFT, PH_RIGHT
	} ph_t;

	typedef struct packed {
		logic [L_W-1:0]   sz;
		logic [L_W-1:0]   psz;
		logic             start;
		logic             free;
		logic [CLS_W-1:0] cls;
		logic [L_W-1:0]   pl;
		logic [L_W-1:0]   nl;
	} rec_t;

	typedef struct packed {
		logic sz;
		logic psz;
		logic flg;
		logic cls;
		logic pl;
		logic nl;
	} rec_en_t;

	// upper bound in bytes of each fibonacci spaced size class
	function automatic logic [17:0] cls_thr(input logic [CLS_W-1:0] idx);
		logic [17:0] t;
		case (idx)
			6'd0:    t = 18'd64;
			6'd1:    t = 18'd96;
			6'd2:    t = 18'd160;
			6'd3:    t = 18'd256;
			6'd4:    t = 18'd416;
			6'd5:    t = 18'd672;
			6'd6:    t = 18'd1088;
			6'd7:    t = 18'd1760;
			6'd8:    t = 18'd2848;
			6'd9:    t = 18'd4608;
			6'd10:   t = 18'd7456;
			6'd11:   t = 18'd12064;
			6'd12:   t = 18'd19520;
			6'd13:   t = 18'd31584;
			6'd14:   t = 18'd51104;
			6'd15:   t = 18'd82688;
			default: t = 18'h3FFFF;
		endcase
		return t;
	endfunction

endpackage

FILE: sv/sfba_if.sv
// request and response channel interfaces of the allocator
// depends on sfba_pkg
interface sfba_req_if;
	import sfba_pkg::*;
	logic        valid;
	logic        ready;
	logic        command;
	logic [23:0] request_bytes;
	logic [15:0] payload_address;

	modport source (output valid, command, request_bytes, payload_address, input ready);
	modport sink (input valid, command, request_bytes, payload_address, output ready);
endinterface

interface sfba_rsp_if;
	import sfba_pkg::*;
	logic           valid;
	logic           ready;
	logic [1:0]     status;
	logic [15:0]    granted_address;
	logic [B_W-1:0] granted_bytes;
	logic [B_W-1:0] used_bytes_now;
	logic [B_W-1:0] peak_bytes_now;

	modport source (output valid, status, granted_address, granted_bytes, used_bytes_now,
		peak_bytes_now, input ready);
	modport sink (input valid, status, granted_address, granted_bytes, used_bytes_now,
		peak_bytes_now, output ready);
endinterface

FILE: sv/sfba_dp.sv
// allocator datapath: heap tag memories, class list heads, working registers, result word
// executes one micro operation per cycle from sfba_ctrl; depends on sfba_pkg
module sfba_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sfba_pkg::dp_cmd_t      cmd,
	output sfba_pkg::dp_stat_t     stat,
	input  logic [7:0]             hdr,
	input  logic                   req_command,
	input  logic [23:0]            req_request_bytes,
	input  logic [15:0]            req_payload_address,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output logic [1:0]             rsp_status,
	output logic [15:0]            rsp_granted_address,
	output logic [16:0]            rsp_granted_bytes,
	output logic [16:0]            rsp_used_bytes_now,
	output logic [16:0]            rsp_peak_bytes_now
);
	import sfba_pkg::*;

	logic [L_W-1:0]   mem_sz  [HEAP_GRANULES];
	logic [L_W-1:0]   mem_psz [HEAP_GRANULES];
	logic [1:0]       mem_flg [HEAP_GRANULES];
	logic [CLS_W-1:0] mem_cls [HEAP_GRANULES];
	logic [L_W-1:0]   mem_pl  [HEAP_GRANULES];
	logic [L_W-1:0]   mem_nl  [HEAP_GRANULES];
	logic [L_W-1:0]   head_mem [SIZE_CLASSES];

	rec_t             rec_q;
	logic [L_W-1:0]   head_q;
	logic [G_W-1:0]   clr_cnt_q;
	logic             is_free_q, req_zero_q, too_big_q, addr_bad_q;
	logic [B_W-1:0]   need_q, val_q;
	logic [CLS_W-1:0] c_q, tcls_q;
	logic [G_W-1:0]   g_q, og_q, tgt_q, pn_q;
	logic [L_W-1:0]   sz_q, lpsz_q, psize_q, p_q, n_q;
	logic             keep_q, psz_en_q;
	logic [15:0]      res_addr_q;
	logic [B_W-1:0]   res_bytes_q, used_q, peak_q;
	logic             out_valid_q;
	logic [1:0]       out_st_q;
	logic [15:0]      out_addr_q;
	logic [B_W-1:0]   out_bytes_q, out_used_q, out_peak_q;

	logic [24:0]      sum_r, aligned;
	logic [B_W-1:0]   need_d;
	logic [15:0]      off;
	logic [L_W-1:0]   needg, remg, r_sum, after_sum;
	logic [G_W-1:0]   l_idx, ng;
	logic [B_W-1:0]   cur_bytes, rec_bytes;
	logic [17:0]      used_sum, split_lim;
	logic             out_free;

	logic             ren;
	logic [G_W-1:0]   raddr, waddr;
	rec_en_t          wen;
	rec_t             wdata;
	logic             hwe;
	logic [CLS_W-1:0] hwaddr;
	logic [L_W-1:0]   hwdata;

	assign sum_r     = {1'b0, req_request_bytes} + {17'b0, hdr} + 25'd15;
	assign aligned   = {sum_r[24:4], 4'b0};
	assign need_d    = (aligned < 25'(MIN_BLOCK)) ? B_W'(MIN_BLOCK) : aligned[B_W-1:0];
	assign off       = req_payload_address - {8'b0, hdr};
	assign needg     = need_q[B_W-1:4];
	assign remg      = sz_q - needg;
	assign ng        = g_q + needg[G_W-1:0];
	assign l_idx     = g_q - lpsz_q[G_W-1:0];
	assign r_sum     = {1'b0, g_q} + sz_q;
	assign after_sum = {1'b0, pn_q} + psize_q;
	assign cur_bytes = {sz_q, 4'b0};
	assign rec_bytes = {rec_q.sz, 4'b0};
	assign used_sum  = {1'b0, used_q} + {1'b0, cur_bytes};
	assign split_lim = {1'b0, need_q} + {10'b0, hdr} + 18'(MIN_BLOCK);
	assign out_free  = !out_valid_q || rsp_ready;

	always_comb begin
		stat.clr_last  = &clr_cnt_q;
		stat.is_free   = is_free_q;
		stat.req_zero  = req_zero_q;
		stat.too_big   = too_big_q;
		stat.addr_bad  = addr_bad_q;
		stat.head_null = head_q[L_W-1];
		stat.c_last    = (c_q == CLS_LAST);
		stat.cls_hit   = ({1'b0, val_q} <= cls_thr(c_q)) || (c_q == CLS_LAST);
		stat.fit       = (rec_q.sz >= needg);
		stat.next_null = rec_q.nl[L_W-1];
		stat.g_start   = rec_q.start;
		stat.g_free    = rec_q.free;
		stat.left_ok   = (g_q != '0) && (lpsz_q <= {1'b0, g_q}) && (lpsz_q != '0);
		stat.r_in      = !r_sum[L_W-1];
		stat.split     = ({1'b0, cur_bytes} >= split_lim);
		stat.out_free  = out_free;
	end

	// memory port steering
	always_comb begin
		ren    = 1'b0;
		raddr  = g_q;
		waddr  = g_q;
		wen    = '0;
		wdata  = '0;
		hwe    = 1'b0;
		hwaddr = c_q;
		hwdata = LINK_NULL;
		case (cmd.op)
			OP_CLR: begin
				waddr       = clr_cnt_q;
				wen         = '{sz: 1'b1, psz: 1'b0, flg: 1'b1, cls: 1'b1, pl: 1'b1, nl: 1'b1};
				wdata.sz    = (clr_cnt_q == '0) ? L_W'(HEAP_GRANULES) : '0;
				wdata.start = (clr_cnt_q == '0);
				wdata.free  = (clr_cnt_q == '0);
				wdata.cls   = (clr_cnt_q == '0) ? CLS_W'(HEAP_CLS) : '0;
				wdata.pl    = LINK_NULL;
				wdata.nl    = LINK_NULL;
				hwe         = (clr_cnt_q < G_W'(SIZE_CLASSES));
				hwaddr      = clr_cnt_q[CLS_W-1:0];
				hwdata      = (clr_cnt_q == G_W'(HEAP_CLS)) ? '0 : LINK_NULL;
			end
			OP_REC_RD: begin
				ren = 1'b1;
			end
			OP_L_RD: begin
				ren   = 1'b1;
				raddr = l_idx;
			end
			OP_R_RD: begin
				ren   = 1'b1;
				raddr = r_sum[G_W-1:0];
			end
			OP_RM_P: begin
				if (p_q[L_W-1]) begin
					hwe    = 1'b1;
					hwaddr = tcls_q;
					hwdata = n_q;
				end else begin
					waddr    = p_q[G_W-1:0];
					wen.nl   = 1'b1;
					wdata.nl = n_q;
				end
			end
			OP_RM_N: begin
				waddr    = n_q[G_W-1:0];
				wen.pl   = !n_q[L_W-1];
				wdata.pl = p_q;
			end
			OP_RM_SELF: begin
				waddr       = tgt_q;
				wen.pl      = 1'b1;
				wen.nl      = 1'b1;
				wen.flg     = 1'b1;
				wdata.pl    = LINK_NULL;
				wdata.nl    = LINK_NULL;
				wdata.start = keep_q;
				wdata.free  = 1'b0;
			end
			OP_SPLIT_SET: begin
				wen.sz   = 1'b1;
				wdata.sz = needg;
			end
			OP_P_NODE: begin
				waddr       = pn_q;
				wen         = '{sz: 1'b1, psz: psz_en_q, flg: 1'b1, cls: 1'b1, pl: 1'b1, nl: 1'b1};
				wdata.sz    = psize_q;
				wdata.psz   = sz_q;
				wdata.start = 1'b1;
				wdata.free  = 1'b1;
				wdata.cls   = c_q;
				wdata.pl    = LINK_NULL;
				wdata.nl    = head_q;
			end
			OP_P_AFTER: begin
				waddr     = after_sum[G_W-1:0];
				wen.psz   = !after_sum[L_W-1];
				wdata.psz = psize_q;
			end
			OP_P_LINK: begin
				waddr    = head_q[G_W-1:0];
				wen.pl   = !head_q[L_W-1];
				wdata.pl = {1'b0, pn_q};
			end
			OP_P_HSET: begin
				hwe    = 1'b1;
				hwdata = {1'b0, pn_q};
			end
			OP_CLR_OG: begin
				waddr       = og_q;
				wen.flg     = 1'b1;
				wdata.start = 1'b0;
				wdata.free  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wen.sz) mem_sz[waddr] <= wdata.sz;
		if (wen.psz) mem_psz[waddr] <= wdata.psz;
		if (wen.flg) mem_flg[waddr] <= {wdata.start, wdata.free};
		if (wen.cls) mem_cls[waddr] <= wdata.cls;
		if (wen.pl) mem_pl[waddr] <= wdata.pl;
		if (wen.nl) mem_nl[waddr] <= wdata.nl;
		if (ren) begin
			rec_q.sz    <= mem_sz[raddr];
			rec_q.psz   <= mem_psz[raddr];
			rec_q.start <= mem_flg[raddr][1];
			rec_q.free  <= mem_flg[raddr][0];
			rec_q.cls   <= mem_cls[raddr];
			rec_q.pl    <= mem_pl[raddr];
			rec_q.nl    <= mem_nl[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (hwe) head_mem[hwaddr] <= hwdata;
		if (cmd.op == OP_HEAD_RD) head_q <= head_mem[c_q];
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				is_free_q   <= req_command;
				req_zero_q  <= (req_request_bytes == '0);
				too_big_q   <= (aligned > 25'(HEAP_GRANULES * 16));
				addr_bad_q  <= (req_payload_address < {8'b0, hdr}) || (off[3:0] != 4'b0);
				need_q      <= need_d;
				val_q       <= need_d;
				c_q         <= '0;
				g_q         <= off[15:4];
				og_q        <= off[15:4];
				res_addr_q  <= '0;
				res_bytes_q <= '0;
			end
			OP_CLS_STEP: begin
				if (!stat.cls_hit) c_q <= c_q + 1'b1;
			end
			OP_CLS_INC: c_q <= c_q + 1'b1;
			OP_G_HEAD:  g_q <= head_q[G_W-1:0];
			OP_G_NEXT:  g_q <= rec_q.nl[G_W-1:0];
			OP_A_TAKE: begin
				tgt_q  <= g_q;
				keep_q <= 1'b1;
				p_q    <= rec_q.pl;
				n_q    <= rec_q.nl;
				tcls_q <= rec_q.cls;
				sz_q   <= rec_q.sz;
			end
			OP_SPLIT_SET: begin
				pn_q     <= ng;
				psize_q  <= remg;
				psz_en_q <= 1'b1;
				sz_q     <= needg;
				val_q    <= {remg, 4'b0};
				c_q      <= '0;
			end
			OP_A_DONE: begin
				res_bytes_q <= cur_bytes;
				res_addr_q  <= {g_q, 4'b0} + {8'b0, hdr};
			end
			OP_F_TAKE: begin
				sz_q        <= rec_q.sz;
				lpsz_q      <= rec_q.psz;
				res_bytes_q <= rec_bytes;
			end
			OP_L_TAKE: begin
				tgt_q  <= l_idx;
				g_q    <= l_idx;
				keep_q <= 1'b1;
				p_q    <= rec_q.pl;
				n_q    <= rec_q.nl;
				tcls_q <= rec_q.cls;
				sz_q   <= sz_q + rec_q.sz;
			end
			OP_R_TAKE: begin
				tgt_q  <= r_sum[G_W-1:0];
				keep_q <= 1'b0;
				p_q    <= rec_q.pl;
				n_q    <= rec_q.nl;
				tcls_q <= rec_q.cls;
				sz_q   <= sz_q + rec_q.sz;
			end
			OP_F_PUSH: begin
				pn_q     <= g_q;
				psize_q  <= sz_q;
				psz_en_q <= 1'b0;
				val_q    <= cur_bytes;
				c_q      <= '0;
			end
			default: begin
			end
		endcase
	end

	// counters, totals and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			used_q      <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_CLR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.op == OP_A_DONE) begin
				used_q <= used_sum[B_W-1:0];
				if (used_sum[B_W-1:0] > peak_q) peak_q <= used_sum[B_W-1:0];
			end
			if (cmd.op == OP_F_TAKE) used_q <= (used_q >= rec_bytes) ? used_q - rec_bytes : '0;
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_st_q    <= cmd.st;
			out_addr_q  <= res_addr_q;
			out_bytes_q <= res_bytes_q;
			out_used_q  <= used_q;
			out_peak_q  <= peak_q;
		end
	end

	assign rsp_valid           = out_valid_q;
	assign rsp_status          = out_st_q;
	assign rsp_granted_address = out_addr_q;
	assign rsp_granted_bytes   = out_bytes_q;
	assign rsp_used_bytes_now  = out_used_q;
	assign rsp_peak_bytes_now  = out_peak_q;

`ifndef ASSERT_OFF
	a_peak_covers_used: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= used_q) else $error("peak below used");
	a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> out_free) else $error("result word overwritten");
	a_class_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_CLS_INC |-> c_q != CLS_LAST) else $error("class walk past top");
`endif

endmodule

FILE: sv/sfba_ctrl.sv
// allocator controller: sequences clearing, fit search, list unlink, split, coalesce and push
// drives micro operations of sfba_dp; depends on sfba_pkg
module sfba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  sfba_pkg::dp_stat_t  stat,
	output sfba_pkg::dp_cmd_t   cmd
);
	import sfba_pkg::*;

	ctrl_state_t state_q, state_d;
	ph_t         ph_q, ph_d;
	rs_t         st_q, st_d;

	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		st_d    = st_q;
		case (state_q)
			S_CLR:     if (stat.clr_last) state_d = S_IDLE;
			S_IDLE:    if (req_valid) state_d = S_DEC;
			S_DEC: begin
				if (stat.is_free) begin
					if (stat.addr_bad) begin
						st_d    = RS_IGNORED;
						state_d = S_FIN;
					end else begin
						state_d = S_F_RD;
					end
				end else if (stat.req_zero) begin
					st_d    = RS_ZERO;
					state_d = S_FIN;
				end else if (stat.too_big) begin
					st_d    = RS_NOFIT;
					state_d = S_FIN;
				end else begin
					state_d = S_A_CLS;
				end
			end
			S_A_CLS:   if (stat.cls_hit) state_d = S_A_HRD;
			S_A_HRD:   state_d = S_A_HCHK;
			S_A_HCHK: begin
				if (!stat.head_null) begin
					state_d = S_A_GRD;
				end else if (stat.c_last) begin
					st_d    = RS_NOFIT;
					state_d = S_FIN;
				end else begin
					state_d = S_A_HRD;
				end
			end
			S_A_GRD:   state_d = S_A_GCHK;
			S_A_GCHK: begin
				if (stat.fit) begin
					ph_d    = PH_ALLOC;
					state_d = S_RM_P;
				end else if (!stat.next_null) begin
					state_d = S_A_GRD;
				end else if (stat.c_last) begin
					st_d    = RS_NOFIT;
					state_d = S_FIN;
				end else begin
					state_d = S_A_HRD;
				end
			end
			S_RM_P:    state_d = S_RM_N;
			S_RM_N:    state_d = S_RM_SELF;
			S_RM_SELF: begin
				case (ph_q)
					PH_ALLOC: state_d = S_A_SPLIT;
					PH_LEFT:  state_d = S_F_CLRG;
					default:  state_d = S_F_PUSH;
				endcase
			end
			S_A_SPLIT: state_d = stat.split ? S_P_CLS : S_A_DONE;
			S_P_CLS:   if (stat.cls_hit) state_d = S_P_HRD;
			S_P_HRD:   state_d = S_P_NODE;
			S_P_NODE:  state_d = S_P_AFTER;
			S_P_AFTER: state_d = S_P_LINK;
			S_P_LINK:  state_d = S_P_HSET;
			S_P_HSET: begin
				if (stat.is_free) begin
					st_d    = RS_DONE;
					state_d = S_FIN;
				end else begin
					state_d = S_A_DONE;
				end
			end
			S_A_DONE: begin
				st_d    = RS_DONE;
				state_d = S_FIN;
			end
			S_F_RD:    state_d = S_F_CHK;
			S_F_CHK: begin
				if (!stat.g_start || stat.g_free) begin
					st_d    = RS_IGNORED;
					state_d = S_FIN;
				end else begin
					state_d = S_F_LCHK;
				end
			end
			S_F_LCHK:  state_d = stat.left_ok ? S_F_LGET : S_F_RRD;
			S_F_LGET: begin
				if (stat.g_free) begin
					ph_d    = PH_LEFT;
					state_d = S_RM_P;
				end else begin
					state_d = S_F_RRD;
				end
			end
			S_F_CLRG:  state_d = S_F_RRD;
			S_F_RRD:   state_d = stat.r_in ? S_F_RGET : S_F_PUSH;
			S_F_RGET: begin
				if (stat.g_free) begin
					ph_d    = PH_RIGHT;
					state_d = S_RM_P;
				end else begin
					state_d = S_F_PUSH;
				end
			end
			S_F_PUSH:  state_d = S_P_CLS;
			S_FIN:     if (stat.out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = OP_NOP;
		cmd.st    = st_q;
		req_ready = 1'b0;
		case (state_q)
			S_CLR:     cmd.op = OP_CLR;
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) cmd.op = OP_LATCH;
			end
			S_A_CLS:   cmd.op = OP_CLS_STEP;
			S_P_CLS:   cmd.op = OP_CLS_STEP;
			S_A_HRD:   cmd.op = OP_HEAD_RD;
			S_P_HRD:   cmd.op = OP_HEAD_RD;
			S_A_HCHK: begin
				if (!stat.head_null) cmd.op = OP_G_HEAD;
				else if (!stat.c_last) cmd.op = OP_CLS_INC;
			end
			S_A_GRD:   cmd.op = OP_REC_RD;
			S_F_RD:    cmd.op = OP_REC_RD;
			S_A_GCHK: begin
				if (stat.fit) cmd.op = OP_A_TAKE;
				else if (!stat.next_null) cmd.op = OP_G_NEXT;
				else if (!stat.c_last) cmd.op = OP_CLS_INC;
			end
			S_RM_P:    cmd.op = OP_RM_P;
			S_RM_N:    cmd.op = OP_RM_N;
			S_RM_SELF: cmd.op = OP_RM_SELF;
			S_A_SPLIT: if (stat.split) cmd.op = OP_SPLIT_SET;
			S_P_NODE:  cmd.op = OP_P_NODE;
			S_P_AFTER: cmd.op = OP_P_AFTER;
			S_P_LINK:  cmd.op = OP_P_LINK;
			S_P_HSET:  cmd.op = OP_P_HSET;
			S_A_DONE:  cmd.op = OP_A_DONE;
			S_F_CHK:   if (stat.g_start && !stat.g_free) cmd.op = OP_F_TAKE;
			S_F_LCHK:  if (stat.left_ok) cmd.op = OP_L_RD;
			S_F_LGET:  if (stat.g_free) cmd.op = OP_L_TAKE;
			S_F_CLRG:  cmd.op = OP_CLR_OG;
			S_F_RRD:   if (stat.r_in) cmd.op = OP_R_RD;
			S_F_RGET:  if (stat.g_free) cmd.op = OP_R_TAKE;
			S_F_PUSH:  cmd.op = OP_F_PUSH;
			S_FIN:     if (stat.out_free) cmd.op = OP_EMIT;
			default:   cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ph_q    <= PH_ALLOC;
			st_q    <= RS_DONE;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			st_q    <= st_d;
		end
	end

endmodule

FILE: sv/segregated_fit_block_allocator.sv
// top level of the segregated fit block allocator: header size register on an apb port,
// controller and datapath; depends on sfba_pkg, sfba_if, sfba_ctrl, sfba_dp
//
//  port   kind        words
//  req    in, v/r     command, request_bytes, payload_address
//  rsp    out, v/r    status, granted_address, granted_bytes, used_bytes_now, peak_bytes_now
//  apb    cfg         header_bytes at byte address 0
//
// one request at a time; an allocate walks the size classes, probes class lists and
// examines free list entries until one fits, and a split pushes the remainder back
// to a class list; a free merges free neighbours on the left and right before the push
// after reset a clearing pass over the heap runs before the first request is taken
// a new request is taken while the previous result word still waits on rsp, and the
// result stage then stalls until rsp takes the waiting word
module segregated_fit_block_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	sfba_req_if.sink                      req,
	sfba_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfba_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import sfba_pkg::*;

	logic [HDR_W-1:0] hdr_q;
	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic             sel_hdr;

	assign pready  = 1'b1;
	assign sel_hdr = (paddr[PADDR_W-1] == REG_HDR);
	assign prdata  = sel_hdr ? {24'b0, hdr_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= HDR_RESET;
		end else if (psel && penable && pwrite && pready && sel_hdr) begin
			hdr_q <= pwdata[HDR_W-1:0];
		end
	end

	sfba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sfba_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.hdr                 (hdr_q),
		.req_command         (req.command),
		.req_request_bytes   (req.request_bytes),
		.req_payload_address (req.payload_address),
		.rsp_valid           (rsp.valid),
		.rsp_ready           (rsp.ready),
		.rsp_status          (rsp.status),
		.rsp_granted_address (rsp.granted_address),
		.rsp_granted_bytes   (rsp.granted_bytes),
		.rsp_used_bytes_now  (rsp.used_bytes_now),
		.rsp_peak_bytes_now  (rsp.peak_bytes_now)
	);

endmodule
